// ----- design/nnd_pkg.sv -----
// Shared constants, types and helpers for the nearest-neighbor image downscaler.
// No dependencies; used by nnd_div and nearest_neighbor_image_downscaler.
package nnd_pkg;

  localparam int SIDE_BITS    = 16;
  localparam int PIXEL_BITS   = 32;
  localparam int ACC_BITS     = 2 * SIDE_BITS;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [SIDE_BITS-1:0] SIDE_MAX = {SIDE_BITS{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIDE_LIMIT    = 2'd2;

  localparam logic [SIDE_BITS-1:0] RESET_SOURCE_WIDTH  = 16'd512;
  localparam logic [SIDE_BITS-1:0] RESET_SOURCE_HEIGHT = 16'd512;
  localparam logic [SIDE_BITS-1:0] RESET_SIDE_LIMIT    = 16'd0;

  typedef enum logic [5:0] {
    ST_SIZE   = 6'b000001,
    ST_W_GO   = 6'b000010,
    ST_W_WAIT = 6'b000100,
    ST_H_GO   = 6'b001000,
    ST_H_WAIT = 6'b010000,
    ST_RUN    = 6'b100000
  } size_state_t;

  // a zero dimension counts as one
  function automatic logic [SIDE_BITS-1:0] side_or_one(input logic [SIDE_BITS-1:0] v);
    side_or_one = (v == '0) ? SIDE_BITS'(1) : v;
  endfunction

  // clamp a scaled side into [1, SIDE_MAX]
  function automatic logic [SIDE_BITS-1:0] clamp_side(input logic [ACC_BITS-1:0] q);
    if (q == '0) begin
      clamp_side = SIDE_BITS'(1);
    end else if (q > ACC_BITS'(SIDE_MAX)) begin
      clamp_side = SIDE_MAX;
    end else begin
      clamp_side = q[SIDE_BITS-1:0];
    end
  endfunction

endpackage

// ----- design/nnd_div.sv -----
// Restoring divider, one quotient bit per cycle, for the output size setup.
// Depends on nnd_pkg for widths.
module nnd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nnd_pkg::ACC_BITS-1:0]  dividend,
  input  logic [nnd_pkg::SIDE_BITS-1:0] divisor,
  output logic                          done,
  output logic [nnd_pkg::ACC_BITS-1:0]  quotient
);

  localparam int CNT_BITS = $clog2(nnd_pkg::ACC_BITS);

  logic                          busy;
  logic [CNT_BITS-1:0]           count;
  logic [nnd_pkg::SIDE_BITS-1:0] rem;
  logic [nnd_pkg::SIDE_BITS-1:0] dvsr;
  logic [nnd_pkg::ACC_BITS-1:0]  quo;
  logic [nnd_pkg::SIDE_BITS:0]   trial;
  logic                          fits;
  logic [nnd_pkg::SIDE_BITS:0]   trial_sub;

  assign trial     = {rem, quo[nnd_pkg::ACC_BITS-1]};
  assign fits      = trial >= {1'b0, dvsr};
  assign trial_sub = trial - {1'b0, dvsr};
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CNT_BITS'(1);
        if (count == CNT_BITS'(nnd_pkg::ACC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder stays below the divisor, so it fits in SIDE_BITS
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      quo <= {quo[nnd_pkg::ACC_BITS-2:0], fits};
      rem <= fits ? trial_sub[nnd_pkg::SIDE_BITS-1:0] : trial[nnd_pkg::SIDE_BITS-1:0];
    end
  end

endmodule

// ----- design/nearest_neighbor_image_downscaler.sv -----
// Nearest-neighbor downscaler: one source pixel per cycle while pixel_ready is high,
// kept pixels out with dest coords; result_valid rises in the cycle after the accept.
// After reset and after every config write to a defined register the output size is set up
// first, directly when no scaling applies, else by two 32-step divides; pixel_ready held low.
// Reset is synchronous: config returns to 512x512 with no limit, all counters clear.
// Depends on nnd_pkg and nnd_div.
module nearest_neighbor_image_downscaler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nnd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [nnd_pkg::SIDE_BITS-1:0]     cfg_data,
  input  logic                              pixel_valid,
  output logic                              pixel_ready,
  input  logic [nnd_pkg::PIXEL_BITS-1:0]    source_pixel,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [nnd_pkg::PIXEL_BITS-1:0]    kept_pixel,
  output logic [nnd_pkg::SIDE_BITS-1:0]     dest_x,
  output logic [nnd_pkg::SIDE_BITS-1:0]     dest_y,
  output logic                              frame_last
);

  localparam int SB = nnd_pkg::SIDE_BITS;
  localparam int AB = nnd_pkg::ACC_BITS;

  // configuration
  logic [SB-1:0] src_width;
  logic [SB-1:0] src_height;
  logic [SB-1:0] side_limit;
  logic          cfg_write;
  logic          cfg_hit;

  // size setup
  nnd_pkg::size_state_t state;
  logic [SB-1:0] w_eff;
  logic [SB-1:0] h_eff;
  logic [SB-1:0] major_side;
  logic          no_scale;
  logic [AB-1:0] product;
  logic [AB-1:0] div_dividend;
  logic          div_start;
  logic          div_done;
  logic [AB-1:0] div_quotient;
  logic [SB-1:0] out_width;
  logic [SB-1:0] out_height;

  // frame walk
  logic [SB-1:0] src_col;
  logic [SB-1:0] src_row;
  logic [SB-1:0] dst_col;
  logic [SB-1:0] dst_row;
  logic [AB-1:0] col_acc;
  logic [AB-1:0] row_acc;
  logic [AB-1:0] col_lim;   // (src_col + 1) * out_width
  logic [AB-1:0] row_lim;   // (src_row + 1) * out_height
  logic          accept;
  logic          col_hit;
  logic          row_hit;
  logic          col_end;
  logic          row_end;
  logic          last_hit;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;
  assign cfg_hit   = cfg_write && (cfg_index == nnd_pkg::REG_SOURCE_WIDTH ||
                                   cfg_index == nnd_pkg::REG_SOURCE_HEIGHT ||
                                   cfg_index == nnd_pkg::REG_SIDE_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= nnd_pkg::RESET_SOURCE_WIDTH;
      src_height <= nnd_pkg::RESET_SOURCE_HEIGHT;
      side_limit <= nnd_pkg::RESET_SIDE_LIMIT;
    end else if (cfg_write) begin
      case (cfg_index)
        nnd_pkg::REG_SOURCE_WIDTH:  src_width  <= cfg_data;
        nnd_pkg::REG_SOURCE_HEIGHT: src_height <= cfg_data;
        nnd_pkg::REG_SIDE_LIMIT:    side_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff        = nnd_pkg::side_or_one(src_width);
  assign h_eff        = nnd_pkg::side_or_one(src_height);
  assign major_side   = (w_eff > h_eff) ? w_eff : h_eff;
  assign no_scale     = (side_limit == '0) || (major_side <= side_limit);
  assign div_dividend = product + AB'(major_side >> 1);
  assign div_start    = (state == nnd_pkg::ST_W_GO) || (state == nnd_pkg::ST_H_GO);

  nnd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (major_side),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      state <= nnd_pkg::ST_SIZE;
    end else begin
      case (state)
        nnd_pkg::ST_SIZE: begin
          if (no_scale) begin
            out_width  <= w_eff;
            out_height <= h_eff;
            state      <= nnd_pkg::ST_RUN;
          end else begin
            product <= AB'(w_eff) * AB'(side_limit);
            state   <= nnd_pkg::ST_W_GO;
          end
        end
        nnd_pkg::ST_W_GO: state <= nnd_pkg::ST_W_WAIT;
        nnd_pkg::ST_W_WAIT: begin
          if (div_done) begin
            out_width <= nnd_pkg::clamp_side(div_quotient);
            product   <= AB'(h_eff) * AB'(side_limit);
            state     <= nnd_pkg::ST_H_GO;
          end
        end
        nnd_pkg::ST_H_GO: state <= nnd_pkg::ST_H_WAIT;
        nnd_pkg::ST_H_WAIT: begin
          if (div_done) begin
            out_height <= nnd_pkg::clamp_side(div_quotient);
            state      <= nnd_pkg::ST_RUN;
          end
        end
        nnd_pkg::ST_RUN: ;
        default: state <= nnd_pkg::ST_SIZE;
      endcase
    end
  end

  assign pixel_ready = (state == nnd_pkg::ST_RUN) && (!result_valid || result_ready);
  assign accept      = pixel_valid & pixel_ready;

  // dest column d maps to source floor(d*w/ow); hit when col_acc falls in this column's span
  assign col_hit  = (dst_col < out_width) && (col_acc < col_lim);
  assign row_hit  = (dst_row < out_height) && (row_acc < row_lim);
  assign col_end  = ({1'b0, src_col} + 17'd1) >= {1'b0, w_eff};
  assign row_end  = ({1'b0, src_row} + 17'd1) >= {1'b0, h_eff};
  assign last_hit = ({1'b0, dst_col} + 17'd1 == {1'b0, out_width}) &&
                    ({1'b0, dst_row} + 17'd1 == {1'b0, out_height});

  always_ff @(posedge clk) begin
    if (rst || cfg_hit || state == nnd_pkg::ST_SIZE || state == nnd_pkg::ST_H_WAIT) begin
      src_col <= '0;
      src_row <= '0;
      dst_col <= '0;
      dst_row <= '0;
      col_acc <= '0;
      row_acc <= '0;
      col_lim <= '0;
      row_lim <= '0;
      if (state == nnd_pkg::ST_H_WAIT && div_done && !rst && !cfg_hit) begin
        col_lim <= AB'(out_width);
        row_lim <= AB'(nnd_pkg::clamp_side(div_quotient));
      end else if (state == nnd_pkg::ST_SIZE && no_scale && !rst && !cfg_hit) begin
        col_lim <= AB'(w_eff);
        row_lim <= AB'(h_eff);
      end
    end else if (accept) begin
      if (col_end) begin
        src_col <= '0;
        dst_col <= '0;
        col_acc <= '0;
        col_lim <= AB'(out_width);
        if (row_end) begin
          src_row <= '0;
          dst_row <= '0;
          row_acc <= '0;
          row_lim <= AB'(out_height);
        end else begin
          src_row <= src_row + SB'(1);
          row_lim <= row_lim + AB'(out_height);
          if (row_hit) begin
            dst_row <= dst_row + SB'(1);
            row_acc <= row_acc + AB'(h_eff);
          end
        end
      end else begin
        src_col <= src_col + SB'(1);
        col_lim <= col_lim + AB'(out_width);
        if (col_hit) begin
          dst_col <= dst_col + SB'(1);
          col_acc <= col_acc + AB'(w_eff);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && col_hit && row_hit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && col_hit && row_hit) begin
      kept_pixel <= source_pixel;
      dest_x     <= dst_col;
      dest_y     <= dst_row;
      frame_last <= last_hit;
    end
  end

endmodule
